[hw/rtl/isbf_pkg.sv]
`timescale 1ns / 1ps
package isbf_pkg;

	localparam int unsigned BLOCK_ENTRIES = 4096;
	localparam int unsigned IDX_W = $clog2(BLOCK_ENTRIES);
	localparam int unsigned CNT_W = $clog2(BLOCK_ENTRIES + 1);
	localparam int unsigned POS_W = 6;
	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(34);
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_VERDICT = 2'd0,
		KIND_ADDED   = 2'd1,
		KIND_FULL    = 2'd2,
		KIND_CLEARED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] address;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       drop;
	} out_item_t;

	// work handed from front to back: a lookup/add/clear job
	typedef struct packed {
		op_t         op;      // OP_BYTE means frame verdict
		logic        eligible; // frame header qualifies for drop
		logic [31:0] key;
	} job_t;

endpackage

[hw/rtl/isbf_front.sv]
`timescale 1ns / 1ps
module isbf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  isbf_pkg::in_item_t  item,
	output logic                job_valid,
	input  logic                job_ready,
	output isbf_pkg::job_t      job
);

	logic [isbf_pkg::POS_W-1:0] pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ver_q;
	logic [31:0] src_q;
	logic [15:0] etype_n;
	logic [3:0]  ver_n;
	logic [31:0] src_n;
	logic [isbf_pkg::POS_W-1:0] pos_n;
	logic        take;
	isbf_pkg::op_t op;

	assign op = isbf_pkg::op_t'(item.operation);
	assign full = !job_ready;
	assign take = push && job_ready;

	// header capture for the current byte
	always_comb begin
		etype_n = etype_q;
		ver_n = ver_q;
		src_n = src_q;
		pos_n = pos_q;
		if (pos_q == isbf_pkg::POS_W'(12)) etype_n = {item.data_byte, etype_q[7:0]};
		else if (pos_q == isbf_pkg::POS_W'(13)) etype_n = {etype_q[15:8], item.data_byte};
		else if (pos_q == isbf_pkg::POS_W'(14)) ver_n = item.data_byte[7:4];
		else if (pos_q >= isbf_pkg::POS_W'(26) && pos_q <= isbf_pkg::POS_W'(29))
			src_n = {src_q[23:0], item.data_byte};
		if (pos_q < isbf_pkg::HDR_LEN) pos_n = pos_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			etype_q <= '0;
			ver_q <= '0;
			src_q <= '0;
		end else if (take && op == isbf_pkg::OP_BYTE) begin
			if (item.last) begin
				pos_q <= '0;
				etype_q <= '0;
				ver_q <= '0;
				src_q <= '0;
			end else begin
				pos_q <= pos_n;
				etype_q <= etype_n;
				ver_q <= ver_n;
				src_q <= src_n;
			end
		end
	end

	// classify into a job
	always_comb begin
		job_valid = 1'b0;
		job.op = op;
		job.eligible = 1'b0;
		job.key = item.address;
		case (op)
			isbf_pkg::OP_BYTE: begin
				job_valid = push && item.last;
				job.key = src_n;
				job.eligible = pos_n >= isbf_pkg::HDR_LEN
					&& etype_n == isbf_pkg::ETHERTYPE_IPV4
					&& ver_n == isbf_pkg::IP_VERSION_4;
			end
			isbf_pkg::OP_ADD, isbf_pkg::OP_CLEAR: job_valid = push;
			default: job_valid = 1'b0;
		endcase
	end

endmodule

[hw/rtl/isbf_queue.sv]
`timescale 1ns / 1ps
module isbf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  isbf_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_take,
	output isbf_pkg::job_t rd_job
);

	isbf_pkg::job_t slot_q [isbf_pkg::QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'(isbf_pkg::QUEUE_DEPTH);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job = slot_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

[hw/rtl/isbf_back.sv]
`timescale 1ns / 1ps
module isbf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_take,
	input  isbf_pkg::job_t      job,
	output logic                empty,
	input  logic                pop,
	output isbf_pkg::out_item_t result
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_CHECK  = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] mem [isbf_pkg::BLOCK_ENTRIES];
	logic [31:0] rdata_q;
	logic [isbf_pkg::CNT_W-1:0] count_q;
	logic [isbf_pkg::CNT_W-1:0] idx_q;   // address being read
	logic        rd_pend_q;             // rdata_q holds entry idx_q-1
	logic        hit_q;                 // match found, or add stored
	isbf_pkg::job_t job_q;
	logic        out_valid_q;
	isbf_pkg::out_item_t out_q;
	logic        mem_we;
	logic        match;
	logic        out_load;

	assign empty = !out_valid_q;
	assign result = out_q;
	assign job_take = state_q == ST_IDLE && job_valid;
	assign match = rd_pend_q && rdata_q == job_q.key;
	assign mem_we = state_q == ST_CHECK && job_q.op == isbf_pkg::OP_ADD && !hit_q
		&& count_q != isbf_pkg::CNT_W'(isbf_pkg::BLOCK_ENTRIES);
	assign out_load = state_q == ST_REPORT && (!out_valid_q || pop);

	// blocklist memory, one read port and one write port
	always_ff @(posedge clk) begin
		if (mem_we) mem[count_q[isbf_pkg::IDX_W-1:0]] <= job_q.key;
		rdata_q <= mem[idx_q[isbf_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (job_take) job_q <= job;
	end

	// sequencer: linear scan over stored entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					hit_q <= 1'b0;
					if (job_valid) begin
						if (job.op == isbf_pkg::OP_CLEAR) state_q <= ST_CHECK;
						else state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) hit_q <= 1'b1;
					if (match || idx_q >= count_q) begin
						rd_pend_q <= 1'b0;
						state_q <= ST_CHECK;
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CHECK: begin
					if (match || mem_we) hit_q <= 1'b1;
					case (job_q.op)
						isbf_pkg::OP_CLEAR: count_q <= '0;
						isbf_pkg::OP_ADD: if (mem_we) count_q <= count_q + 1'b1;
						default: ;
					endcase
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (out_load) begin
						case (job_q.op)
							isbf_pkg::OP_BYTE: begin
								out_q.kind <= isbf_pkg::KIND_VERDICT;
								out_q.drop <= job_q.eligible && hit_q;
							end
							isbf_pkg::OP_ADD: begin
								out_q.kind <= hit_q ? isbf_pkg::KIND_ADDED
									: isbf_pkg::KIND_FULL;
								out_q.drop <= 1'b0;
							end
							default: begin
								out_q.kind <= isbf_pkg::KIND_CLEARED;
								out_q.drop <= 1'b0;
							end
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/ipv4_source_blocklist_filter.sv]
`timescale 1ns / 1ps
// Frame bytes are taken one per cycle unless full; only a frame's last byte, an add
// or a clear makes a job for the lookup engine, buffered in a two-entry queue.
// A lookup or add scans the blocklist before its result (a clear skips the scan):
// the engine reads the blocklist one entry per cycle until a match or the fill count.
// Each item's result waits in an output register until popped.
// arst_n low empties the blocklist (fill count zero), queue and header capture.
module ipv4_source_blocklist_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  isbf_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output isbf_pkg::out_item_t out_item
);

	logic q_wr_valid, q_wr_ready, q_rd_valid, q_take;
	isbf_pkg::job_t q_wr_job, q_rd_job;

	isbf_front u_front (
		.clk, .arst_n, .push, .full, .item(in_item),
		.job_valid(q_wr_valid), .job_ready(q_wr_ready), .job(q_wr_job)
	);

	isbf_queue u_queue (
		.clk, .arst_n, .wr_valid(q_wr_valid), .wr_ready(q_wr_ready), .wr_job(q_wr_job),
		.rd_valid(q_rd_valid), .rd_take(q_take), .rd_job(q_rd_job)
	);

	isbf_back u_back (
		.clk, .arst_n, .job_valid(q_rd_valid), .job_take(q_take), .job(q_rd_job),
		.empty, .pop, .result(out_item)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !q_wr_ready) else $error("full without queue full");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item))) else $error("result lost");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_rd_valid) else $error("engine took from empty queue");
`endif

endmodule
